>>> rtl/haar_wavelet_threshold_unit_defines.svh
// ---------------------------------------------------------------------------
// Haar wavelet threshold unit: assertion macros
// Shared property templates for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef HAAR_WAVELET_THRESHOLD_UNIT_DEFINES_SVH
`define HAAR_WAVELET_THRESHOLD_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define HWT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define HWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// state right after a reset cycle
`define HWT_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hwt_pkg.sv
// ---------------------------------------------------------------------------
// hwt_pkg
// Constants, register codes and transaction types of the Haar wavelet unit.
// ---------------------------------------------------------------------------
package hwt_pkg;

  localparam int MAX_LOG2    = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int VALUE_BITS  = 26;
  localparam int ADDR_W      = MAX_LOG2;
  localparam int CNT_W       = MAX_LOG2 + 1;
  localparam int PAIR_W      = (ADDR_W > 1) ? ADDR_W - 1 : 1;
  localparam int BUF_DEPTH   = 1 << MAX_LOG2;
  localparam int LVL_W       = $clog2(MAX_LOG2 + 1);

  localparam int LOG_W       = 4;
  localparam int THR_W       = 15;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOG2_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE   = 2'd2;

  localparam logic [LOG_W-1:0] RST_LOG2_LENGTH = 4'd10;
  localparam logic [THR_W-1:0] RST_THRESHOLD   = 15'd30;
  localparam logic             RST_INVERSE     = 1'b0;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = 2;
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_PTR_W = 1;

  typedef struct packed {
    logic                          is_read;
    logic [ADDR_W-1:0]             addr;
    logic                          last;
    logic                          start;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [LVL_W-1:0]              levels;
    logic                          inv;
    logic [THR_W-1:0]              thr;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } res_t;

  function automatic logic [LVL_W-1:0] clamp_levels(input logic [LOG_W-1:0] l);
    logic [LVL_W-1:0] r;
    if (l == '0) begin
      r = LVL_W'(1);
    end else if (int'(l) > MAX_LOG2) begin
      r = LVL_W'(MAX_LOG2);
    end else begin
      r = LVL_W'(l);
    end
    return r;
  endfunction

endpackage

>>> rtl/haar_wavelet_threshold_unit.sv
// ---------------------------------------------------------------------------
// haar_wavelet_threshold_unit
// Multi-level Haar transform with hard thresholding (forward) or plain
// reconstruction (inverse) over blocks of 2^L samples.
//
//   channel   ports                                   handshake
//   input     in_kind, in_sample                      push / full
//   result    out_value, out_last                     empty / pop
//   config    cfg_index, cfg_data                     cfg_wr_en
//
// A push is taken in the engine's idle state; a read passes through ST_RDW for
// the result RAM's registered read. The push that completes a block starts the
// transform, one buffer read per cycle. Reset is synchronous; the sample and
// coefficient RAMs need no clearing. Input stalls only on a full command queue;
// results wait on a full output queue and while a transform runs.
// ---------------------------------------------------------------------------
module haar_wavelet_threshold_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   in_kind,
  input  logic signed [hwt_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [hwt_pkg::VALUE_BITS-1:0]  out_value,
  output logic                                   out_last,
  input  logic                                   cfg_wr_en,
  input  logic [hwt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [hwt_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import hwt_pkg::*;

  cmd_t q_wdata;
  cmd_t q_rdata;
  logic q_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  res_t r_wdata;
  res_t r_rdata;
  logic r_push;
  logic r_full;

  assign full      = q_full;
  assign out_value = r_rdata.value;
  assign out_last  = r_rdata.last;

  hwt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .in_kind   (in_kind),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  hwt_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  hwt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_rdata),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .res_full  (r_full),
    .res_push  (r_push),
    .res_data  (r_wdata)
  );

  hwt_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (r_push),
    .wr_data (r_wdata),
    .full    (r_full),
    .rd_en   (pop),
    .rd_data (r_rdata),
    .empty   (empty)
  );

endmodule

>>> rtl/hwt_ram.sv
// ---------------------------------------------------------------------------
// hwt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module hwt_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/hwt_cmdq.sv
// ---------------------------------------------------------------------------
// hwt_cmdq
// Command queue between the classifier and the execution engine.
// ---------------------------------------------------------------------------
module hwt_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  hwt_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output hwt_pkg::cmd_t rd_data,
  output logic          empty
);
  import hwt_pkg::*;

  cmd_t                mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_PTR_W:0]   count_r;
  logic                  do_wr;
  logic                  do_rd;

  assign full    = count_r == (CMDQ_PTR_W+1)'(CMDQ_DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/hwt_outq.sv
// ---------------------------------------------------------------------------
// hwt_outq
// Result queue, decouples result delivery from the execution engine.
// ---------------------------------------------------------------------------
module hwt_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  hwt_pkg::res_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output hwt_pkg::res_t rd_data,
  output logic          empty
);
  import hwt_pkg::*;

  res_t                  mem_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_r;
  logic [OUTQ_PTR_W-1:0] rd_ptr_r;
  logic [OUTQ_PTR_W:0]   count_r;
  logic                  do_wr;
  logic                  do_rd;

  assign full    = count_r == (OUTQ_PTR_W+1)'(OUTQ_DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/hwt_front.sv
// ---------------------------------------------------------------------------
// hwt_front
// Config registers, load/readout bookkeeping and command classification.
// ---------------------------------------------------------------------------
module hwt_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [hwt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hwt_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  push,
  input  logic                                  in_kind,
  input  logic signed [hwt_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                  q_full,
  output logic                                  q_push,
  output hwt_pkg::cmd_t                         q_data
);
  import hwt_pkg::*;

  logic [LOG_W-1:0]  log2_r;
  logic [THR_W-1:0]  thr_r;
  logic              inv_r;
  logic [ADDR_W-1:0] load_cnt_r;
  logic [ADDR_W-1:0] rd_cnt_r;
  logic [CNT_W-1:0]  rd_len_r;
  logic              ready_r;

  logic [LVL_W-1:0]  lvls;
  logic [CNT_W-1:0]  blk_len;
  logic              load_done;
  logic              rd_last;
  logic              accept;
  logic              is_read;

  assign lvls      = clamp_levels(log2_r);
  assign blk_len   = CNT_W'(1) << lvls;
  assign load_done = ({1'b0, load_cnt_r} + CNT_W'(1)) >= blk_len;
  assign rd_last   = ({1'b0, rd_cnt_r} + CNT_W'(1)) >= rd_len_r;
  assign accept    = push && !q_full;
  assign is_read   = in_kind == KIND_READ;
  assign q_push    = accept && (!is_read || ready_r);

  always_comb begin
    q_data         = '0;
    q_data.is_read = is_read;
    q_data.addr    = is_read ? rd_cnt_r : load_cnt_r;
    q_data.last    = rd_last;
    q_data.start   = load_done;
    q_data.sample  = in_sample;
    q_data.levels  = lvls;
    q_data.inv     = inv_r;
    q_data.thr     = thr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r <= RST_LOG2_LENGTH;
      thr_r  <= RST_THRESHOLD;
      inv_r  <= RST_INVERSE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOG2_LENGTH:    log2_r <= cfg_data[LOG_W-1:0];
        REG_ZERO_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        REG_INVERSE_MODE:   inv_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      rd_cnt_r   <= '0;
      rd_len_r   <= CNT_W'(1);
      ready_r    <= 1'b0;
    end else if (accept) begin
      if (!is_read) begin
        if (load_done) begin
          load_cnt_r <= '0;
          rd_cnt_r   <= '0;
          rd_len_r   <= blk_len;
          ready_r    <= 1'b1;
        end else begin
          load_cnt_r <= load_cnt_r + 1'b1;
        end
      end else if (ready_r) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
        if (rd_last) ready_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/hwt_back.sv
// ---------------------------------------------------------------------------
// hwt_back
// Execution engine: sample store, level-by-level Haar transform over
// ping-pong buffers, and result readout.
// ---------------------------------------------------------------------------
module hwt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  hwt_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output hwt_pkg::res_t res_data
);
  import hwt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RDW  = 2'd1;
  localparam logic [1:0] ST_XF   = 2'd2;

  localparam logic [1:0] WPH_IDLE = 2'd0;
  localparam logic [1:0] WPH_LO   = 2'd1;
  localparam logic [1:0] WPH_HI   = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [1:0]                   wph_r, wph_nxt;
  logic                         v1_r;
  logic                         odd1_r;
  logic [PAIR_W-1:0]            pair1_r;
  logic [PAIR_W-1:0]            pi_r;
  logic [LVL_W-1:0]             lvls_r;
  logic [LVL_W-1:0]             lvl_r;
  logic                         inv_r;
  logic [THR_W-1:0]             thr_r;
  logic [ADDR_W-1:0]            len_r;
  logic [CNT_W-1:0]             rc_r;
  logic signed [VALUE_BITS-1:0] a_r;
  logic signed [VALUE_BITS-1:0] res0_r;
  logic signed [VALUE_BITS-1:0] res1_r;
  logic                         rd_last_r;

  logic [CNT_W-1:0]             two_len;
  logic                         rd_issue;
  logic [ADDR_W-1:0]            xf_raddr;
  logic                         dst_is_r;
  logic                         src_is_l;
  logic signed [VALUE_BITS-1:0] src_data;
  logic                         pair_done;
  logic                         lvl_end;
  logic signed [VALUE_BITS:0]   sum;
  logic signed [VALUE_BITS:0]   diff;
  logic [ADDR_W-1:0]            xf_waddr;
  logic signed [VALUE_BITS-1:0] wval;
  logic signed [VALUE_BITS-1:0] thr_pos;
  logic signed [VALUE_BITS-1:0] thr_neg;
  logic                         small_val;
  logic [VALUE_BITS-1:0]        xf_wdata;
  logic                         xf_we;
  logic                         start_xf;

  logic [SAMPLE_BITS-1:0]       l_rdata;
  logic [VALUE_BITS-1:0]        p_rdata;
  logic [VALUE_BITS-1:0]        r_rdata;
  logic                         l_we;
  logic                         p_we;
  logic                         r_we;
  logic [ADDR_W-1:0]            r_raddr;

  // transform engine
  assign two_len  = {len_r, 1'b0};
  assign rd_issue = (state_r == ST_XF) && (rc_r < two_len);
  assign xf_raddr = inv_r ? (ADDR_W'(rc_r >> 1) + (rc_r[0] ? len_r : ADDR_W'(0)))
                          : rc_r[ADDR_W-1:0];
  assign dst_is_r = ~(lvls_r[0] ^ lvl_r[0]);
  assign src_is_l = lvl_r == LVL_W'(1);

  // inverse: details always come from the loaded samples, approximations
  // from the previous level; forward: the pong RAM holds the approximations
  always_comb begin
    if (src_is_l || (inv_r && odd1_r)) begin
      src_data = {{(VALUE_BITS-SAMPLE_BITS){l_rdata[SAMPLE_BITS-1]}}, l_rdata};
    end else if (!inv_r || dst_is_r) begin
      src_data = p_rdata;
    end else begin
      src_data = r_rdata;
    end
  end

  assign pair_done = v1_r && odd1_r;
  assign sum  = {a_r[VALUE_BITS-1], a_r} + {src_data[VALUE_BITS-1], src_data};
  assign diff = {a_r[VALUE_BITS-1], a_r} - {src_data[VALUE_BITS-1], src_data};
  assign lvl_end = (state_r == ST_XF) && (rc_r == two_len) && !v1_r && (wph_r == WPH_HI);

  always_comb begin
    if (inv_r) begin
      xf_waddr = (wph_r == WPH_LO) ? ADDR_W'({pi_r, 1'b0}) : ADDR_W'({pi_r, 1'b1});
    end else begin
      xf_waddr = (wph_r == WPH_LO) ? ADDR_W'(pi_r) : ADDR_W'(pi_r) + len_r;
    end
  end

  assign wval      = (wph_r == WPH_LO) ? res0_r : res1_r;
  assign thr_pos   = $signed({{(VALUE_BITS-THR_W){1'b0}}, thr_r});
  assign thr_neg   = -thr_pos;
  assign small_val = !inv_r && (wval < thr_pos) && (wval > thr_neg);
  assign xf_wdata  = small_val ? '0 : wval;
  assign xf_we     = (state_r == ST_XF) && (wph_r != WPH_IDLE);

  // command handling
  assign cmd_pop  = (state_r == ST_IDLE) && !cmd_empty && (!cmd.is_read || !res_full);
  assign start_xf = cmd_pop && !cmd.is_read && cmd.start;
  assign l_we     = cmd_pop && !cmd.is_read;
  assign p_we     = inv_r ? (xf_we && !dst_is_r) : (xf_we && (wph_r == WPH_LO));
  assign r_we     = inv_r ? (xf_we && dst_is_r) : xf_we;
  assign r_raddr  = (state_r == ST_XF) ? xf_raddr : cmd.addr;

  assign res_push       = state_r == ST_RDW;
  assign res_data.value = r_rdata;
  assign res_data.last  = rd_last_r;

  hwt_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(BUF_DEPTH)) u_load_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (cmd.addr),
    .wdata (cmd.sample),
    .raddr (xf_raddr),
    .rdata (l_rdata)
  );

  hwt_ram #(.WIDTH(VALUE_BITS), .DEPTH(BUF_DEPTH)) u_pong_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (xf_waddr),
    .wdata (xf_wdata),
    .raddr (xf_raddr),
    .rdata (p_rdata)
  );

  hwt_ram #(.WIDTH(VALUE_BITS), .DEPTH(BUF_DEPTH)) u_result_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (xf_waddr),
    .wdata (xf_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop && cmd.is_read) begin
          state_nxt = ST_RDW;
        end else if (start_xf) begin
          state_nxt = ST_XF;
        end
      end
      ST_RDW: state_nxt = ST_IDLE;
      ST_XF: begin
        if (lvl_end && (lvl_r == lvls_r)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wph_nxt = WPH_IDLE;
    if (pair_done) begin
      wph_nxt = WPH_LO;
    end else if (wph_r == WPH_LO) begin
      wph_nxt = WPH_HI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wph_r   <= WPH_IDLE;
      v1_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wph_r   <= wph_nxt;
      v1_r    <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    odd1_r  <= rc_r[0];
    pair1_r <= PAIR_W'(rc_r >> 1);
    if (cmd_pop && cmd.is_read) rd_last_r <= cmd.last;
    if (v1_r && !odd1_r) a_r <= src_data;
    if (pair_done) begin
      pi_r   <= pair1_r;
      res0_r <= inv_r ? sum[VALUE_BITS-1:0] : sum[VALUE_BITS:1];
      res1_r <= inv_r ? diff[VALUE_BITS-1:0] : diff[VALUE_BITS:1];
    end
    if (start_xf) begin
      lvls_r <= cmd.levels;
      inv_r  <= cmd.inv;
      thr_r  <= cmd.thr;
      lvl_r  <= LVL_W'(1);
      rc_r   <= '0;
      len_r  <= cmd.inv ? ADDR_W'(1) : ADDR_W'(1) << (cmd.levels - LVL_W'(1));
    end else if (lvl_end) begin
      lvl_r <= lvl_r + LVL_W'(1);
      rc_r  <= '0;
      len_r <= inv_r ? (len_r << 1) : (len_r >> 1);
    end else if (rd_issue) begin
      rc_r <= rc_r + CNT_W'(1);
    end
  end

endmodule

>>> rtl/hwt_checker.sv
// ---------------------------------------------------------------------------
// hwt_checker
// Port-level checks of the Haar wavelet unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "haar_wavelet_threshold_unit_defines.svh"

module hwt_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  push,
  input logic                                  full,
  input logic                                  empty,
  input logic                                  pop,
  input logic signed [hwt_pkg::VALUE_BITS-1:0] out_value,
  input logic                                  out_last
);

  `HWT_ASSERT_RST(a_rst_empty, empty, "result queue not empty after reset")
  `HWT_ASSERT_RST(a_rst_not_full, !full, "input queue full after reset")
  `HWT_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_value) && $stable(out_last), "waiting result changed")
  `HWT_ASSERT_NOW(a_empty_by_pop, $rose(empty) && $past(rst_n), $past(pop), "result lost without a pop")
  `HWT_ASSERT_NOW(a_full_by_push, $rose(full) && $past(rst_n), $past(push), "input queue filled without a push")

endmodule

bind haar_wavelet_threshold_unit hwt_checker u_chk (.*);

>>> tb/tb_haar_wavelet_threshold_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_haar_wavelet_threshold_unit
// Self-checking bench for the Haar wavelet threshold unit. A short table
// covers the field extremes, both modes, the level clamp, empty reads and
// reloading during readout. Random phases follow with small blocks and one
// maximum-length block. Each read result is checked against a bit-accurate
// predictor of the transform, under varying push/pop backpressure.
// ----------------------------------------------------------------------------
module tb_haar_wavelet_threshold_unit;
  import hwt_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int XFORM_WAIT   = 2200;
  localparam int DRAIN_LIMIT  = 40000;
  localparam int NUM_PHASES   = 12;
  localparam int NUM_OPENING  = 28;

  typedef struct {
    bit                            is_cfg;
    logic [CFG_IDX_W-1:0]          reg_idx;
    logic [CFG_DATA_W-1:0]         reg_val;
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] smp;
    bit                            typed;
    logic signed [VALUE_BITS-1:0]  val;
    logic                          lst;
  } opening_row_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          push      = 1'b0;
  logic                          full;
  logic                          in_kind   = KIND_PUSH;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          empty;
  logic                          pop       = 1'b0;
  logic signed [VALUE_BITS-1:0]  out_value;
  logic                          out_last;
  logic                          cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = REG_LOG2_LENGTH;
  logic [CFG_DATA_W-1:0]         cfg_data  = '0;

  int    errors       = 0;
  int    cycle_cnt    = 0;
  int    snd_idle_pct = 19;
  int    rcv_idle_pct = 88;
  res_t  coeffs_due [$];

  // predictor state
  logic [LOG_W-1:0] lvl_reg = RST_LOG2_LENGTH;
  logic [THR_W-1:0] thr_reg = RST_THRESHOLD;
  logic             inv_reg = RST_INVERSE;
  longint           work_mem    [BUF_DEPTH];
  longint           coeff_mem   [BUF_DEPTH];
  longint           scratch_mem [BUF_DEPTH];
  int unsigned      loaded      = 0;
  int unsigned      read_pos    = 0;
  int unsigned      block_len   = 1;
  bit               block_ready = 1'b0;

  opening_row_t opening_steps [NUM_OPENING];

  haar_wavelet_threshold_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_kind   (in_kind),
    .in_sample (in_sample),
    .empty     (empty),
    .pop       (pop),
    .out_value (out_value),
    .out_last  (out_last),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint zero_small(input longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    return (mag < longint'(thr_reg)) ? 64'sd0 : v;
  endfunction

  function automatic bit haar_step(input logic kind, input logic signed [SAMPLE_BITS-1:0] smp,
                                   output res_t res);
    int unsigned n, lvl, idx, i, len;
    longint      a, b;
    bit          fin;
    res = '0;
    if (kind == KIND_PUSH) begin
      if (lvl_reg == '0) lvl = 1;
      else if (int'(lvl_reg) > MAX_LOG2) lvl = MAX_LOG2;
      else lvl = int'(lvl_reg);
      n = 1 << lvl;
      work_mem[loaded % BUF_DEPTH] = longint'(smp);
      loaded++;
      if (loaded >= n) begin
        if (inv_reg) begin
          for (i = 0; i < n; i++) scratch_mem[i] = work_mem[i];
          for (len = 1; len <= (n >> 1); len = len << 1) begin
            for (i = 0; i < len; i++) begin
              a = scratch_mem[i];
              b = scratch_mem[i + len];
              coeff_mem[2 * i]     = a + b;
              coeff_mem[2 * i + 1] = a - b;
            end
            for (i = 0; i < 2 * len; i++) scratch_mem[i] = coeff_mem[i];
          end
        end else begin
          for (len = n >> 1; len >= 1; len = len >> 1) begin
            for (i = 0; i < len; i++) begin
              a = work_mem[2 * i];
              b = work_mem[2 * i + 1];
              coeff_mem[i]       = zero_small((a + b) >>> 1);
              coeff_mem[i + len] = zero_small((a - b) >>> 1);
            end
            for (i = 0; i < 2 * len; i++) work_mem[i] = coeff_mem[i];
          end
        end
        block_len   = n;
        read_pos    = 0;
        loaded      = 0;
        block_ready = 1'b1;
      end
      return 1'b0;
    end
    if (!block_ready) return 1'b0;
    idx       = read_pos % BUF_DEPTH;
    fin       = (read_pos + 1 >= block_len);
    res.value = VALUE_BITS'(coeff_mem[idx]);
    res.last  = fin;
    read_pos++;
    if (fin) block_ready = 1'b0;
    return 1'b1;
  endfunction

  task automatic offer_item(input logic kind, input logic signed [SAMPLE_BITS-1:0] smp,
                            input bit typed, input logic signed [VALUE_BITS-1:0] tv,
                            input logic tl);
    res_t res;
    bit   got;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    in_kind   <= kind;
    in_sample <= smp;
    @(posedge clk);
    while (full) @(posedge clk);
    got = haar_step(kind, smp, res);
    if (got) begin
      if (typed) begin
        res.value = tv;
        res.last  = tl;
      end
      coeffs_due.push_back(res);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_LOG2_LENGTH:    lvl_reg = data[LOG_W-1:0];
      REG_ZERO_THRESHOLD: thr_reg = data[THR_W-1:0];
      REG_INVERSE_MODE:   inv_reg = data[0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // drain outstanding results, then let a transform in flight finish
  task automatic quiesce();
    int n;
    n = 0;
    push <= 1'b0;
    while (coeffs_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (XFORM_WAIT) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (coeffs_due.size() == 0) begin
          $error("unexpected transaction: value %0d last %0b", out_value, out_last);
          errors++;
        end else begin
          want = coeffs_due.pop_front();
          if (out_value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_value);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_haar_wavelet_threshold_unit NOT OK");
      $finish;
    end
  end

  initial begin
    int                            ph, budget, count, pend, r, ext_pct, v;
    bit                            busy;
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [LOG_W-1:0]              lv;
    logic [THR_W-1:0]              th;
    logic                          iv;

    opening_steps = '{
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          0, 0,              0},
      '{1, REG_LOG2_LENGTH,    1,       KIND_PUSH, 0,          0, 0,              0},
      '{1, REG_ZERO_THRESHOLD, 0,       KIND_PUSH, 0,          0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sh7fff,  0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sh8000,  0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          1, -26'sd1,        0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          1, 26'sd32767,     1},
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          0, 0,              0},
      '{1, REG_INVERSE_MODE,   1,       KIND_PUSH, 0,          0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sh8000,  0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sh8000,  0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          1, -26'sd65536,    0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          1, 26'sd0,         1},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sd1,     0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sd2,     0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sd7,     0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sd9,     0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          0, 0,              0},
      '{1, REG_LOG2_LENGTH,    0,       KIND_PUSH, 0,          0, 0,              0},
      '{1, REG_ZERO_THRESHOLD, 15'h7fff, KIND_PUSH, 0,         0, 0,              0},
      '{1, REG_INVERSE_MODE,   0,       KIND_PUSH, 0,          0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sd5,     0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sd3,     0, 0,              0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          1, 26'sd0,         0},
      '{0, REG_LOG2_LENGTH,    0,       KIND_READ, 0,          1, 26'sd0,         1},
      '{0, REG_LOG2_LENGTH,    0,       KIND_PUSH, 16'sh8000,  0, 0,              0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    busy = 1'b0;
    foreach (opening_steps[k]) begin
      if (opening_steps[k].is_cfg) begin
        if (busy) begin
          quiesce();
          busy = 1'b0;
        end
        write_reg(opening_steps[k].reg_idx, opening_steps[k].reg_val);
      end else begin
        offer_item(opening_steps[k].kind, opening_steps[k].smp, opening_steps[k].typed,
                   opening_steps[k].val, opening_steps[k].lst);
        busy = 1'b1;
      end
    end

    // a phase may end mid-load, so the next register set lands on a partial block
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        snd_idle_pct = 19;
        rcv_idle_pct = 88;
      end else if (ph < 8) begin
        snd_idle_pct = 88;
        rcv_idle_pct = 19;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      quiesce();
      ext_pct = 10;
      budget  = 36;
      case (ph)
        0:  begin lv = 4'd2;  th = THR_W'($urandom_range(0, 40));  iv = 1'b0; end
        1:  begin lv = 4'd3;  th = '0;                             iv = 1'b1; end
        2:  begin lv = 4'd1;  th = 15'h7fff;                       iv = 1'b0; end
        3:  begin lv = 4'd4;  th = THR_W'($urandom_range(0, 100)); iv = 1'b0; end
        4:  begin lv = 4'd2;  th = THR_W'($urandom());             iv = 1'b1; end
        5:  begin
          lv = 4'd15; th = 15'd30; iv = 1'b1;
          ext_pct = 60;
          budget  = 1060;
        end
        6:  begin lv = 4'd3;  th = '0;                             iv = 1'b0; end
        7:  begin lv = 4'd5;  th = THR_W'($urandom_range(0, 200)); iv = 1'b0; end
        8:  begin lv = 4'd1;  th = THR_W'($urandom());             iv = 1'b1; end
        9:  begin lv = 4'd0;  th = THR_W'($urandom_range(0, 50));  iv = 1'b0; end
        10: begin lv = 4'd4;  th = THR_W'($urandom());             iv = 1'b0; end
        default: begin lv = 4'd6; th = THR_W'($urandom_range(0, 60)); iv = 1'b0; end
      endcase
      write_reg(REG_LOG2_LENGTH, CFG_DATA_W'(lv));
      write_reg(REG_ZERO_THRESHOLD, CFG_DATA_W'(th));
      write_reg(REG_INVERSE_MODE, CFG_DATA_W'(iv));

      count = 0;
      while (count < budget) begin
        pend = block_ready ? int'(block_len - read_pos) : 0;
        r    = $urandom_range(0, 99);
        kind = ((pend > 0) ? (r < 80) : (r >= 95)) ? KIND_READ : KIND_PUSH;
        if (kind == KIND_PUSH || pend > 0) count++;
        r = $urandom_range(0, 99);
        if (r < ext_pct) begin
          smp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end else if (r < ext_pct + 30) begin
          v   = int'($urandom_range(0, 160)) - 80;
          smp = SAMPLE_BITS'(v);
        end else begin
          smp = SAMPLE_BITS'($urandom());
        end
        offer_item(kind, smp, 1'b0, '0, 1'b0);
      end
    end

    quiesce();
    if (coeffs_due.size() != 0) begin
      $error("%0d results never arrived", coeffs_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_haar_wavelet_threshold_unit OK");
    end else begin
      $display("tb_haar_wavelet_threshold_unit NOT OK");
    end
    $finish;
  end

endmodule
